/* rtl/assert_macros.svh */
// assertion macros used by the checker file flrs_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/flrs_pkg.sv */
// shared types, widths and key folding for the record sorter
// no dependencies
package flrs_pkg;

    localparam int KEY_W = 8;
    localparam int TAG_W = 6;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [TAG_W-1:0] t_tag;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

    // ascii upper case folded to lower case, all other bytes as they are
    function automatic t_key fold_key(input t_key c);
        t_key r;
        r = c;
        if (c inside {[8'h41:8'h5A]}) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

/* rtl/flrs_cell.sv */
// one cell of the insertion chain: holds one record, compares the incoming
// item against it and passes records on to its neighbours; uses flrs_pkg
module flrs_cell (
    input  logic                i_clk,
    input  flrs_pkg::t_cell_ctl i_ctl,
    input  logic                i_occupied,
    input  flrs_pkg::t_key      i_new_key,
    input  flrs_pkg::t_tag      i_new_tag,
    input  logic                i_prev_gt,
    input  flrs_pkg::t_key      i_prev_key,
    input  flrs_pkg::t_tag      i_prev_tag,
    input  flrs_pkg::t_key      i_next_key,
    input  flrs_pkg::t_tag      i_next_tag,
    output logic                o_gt,
    output flrs_pkg::t_key      o_key,
    output flrs_pkg::t_tag      o_tag
);

    flrs_pkg::t_key r_key;
    flrs_pkg::t_tag r_tag;
    flrs_pkg::t_key n_key;
    flrs_pkg::t_tag n_tag;

    // empty cells count as larger than any key; equal keys keep arrival order
    assign o_gt = !i_occupied ||
                  (flrs_pkg::fold_key(i_new_key) < flrs_pkg::fold_key(r_key));

    always_comb begin
        n_key = r_key;
        n_tag = r_tag;
        if (i_ctl.load && o_gt) begin
            if (i_prev_gt) begin
                n_key = i_prev_key;
                n_tag = i_prev_tag;
            end else begin
                n_key = i_new_key;
                n_tag = i_new_tag;
            end
        end else if (i_ctl.shift) begin
            n_key = i_next_key;
            n_tag = i_next_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_tag <= n_tag;
    end

    assign o_key = r_key;
    assign o_tag = r_tag;

endmodule

/* rtl/first_letter_record_sorter.sv */
// record sorter top level: fill count, run control and the chain of cells
// uses flrs_pkg and flrs_cell
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+--------------------------------------------
//  input   | i_valid | o_stall | i_first_char, i_record_tag, i_last_record
//  output  | o_valid | i_stall | o_sorted_tag, o_sorted_char, o_overflow,
//          |         |         | o_last_out
//
// one record is taken per cycle while loading; each is inserted into the
// chain in that cycle unless it is full, so the set is always in order
// the first result is shown in the cycle after the last record; the N held
// results then leave one per cycle while i_stall is low, each shifting the
// chain by one cell; o_stall is high all through the run, stalls included
// reset clears the fill count, run flag and overflow flag; cell contents are
// not reset and are never shown before being written
module first_letter_record_sorter #(
    parameter int MAX_RECORDS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_first_char,
    input  logic [5:0]           i_record_tag,
    input  logic                 i_last_record,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [5:0]           o_sorted_tag,
    output logic [7:0]           o_sorted_char,
    output logic                 o_overflow,
    output logic                 o_last_out
);

    localparam int CNT_W = $clog2(MAX_RECORDS + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_drain;
    logic             n_drain;
    logic             r_overflow;
    logic             n_overflow;

    logic             w_in_acc;
    logic             w_out_acc;
    logic             w_full;
    flrs_pkg::t_cell_ctl w_ctl;

    logic             w_occ [MAX_RECORDS];
    logic             w_gt  [MAX_RECORDS];
    flrs_pkg::t_key   w_key [MAX_RECORDS];
    flrs_pkg::t_tag   w_tag [MAX_RECORDS];

    assign o_stall   = r_drain;
    assign o_valid   = r_drain;
    assign w_in_acc  = i_valid && !r_drain;
    assign w_out_acc = r_drain && !i_stall;
    assign w_full    = (r_count == CNT_W'(MAX_RECORDS));

    assign w_ctl.load  = w_in_acc && !w_full;
    assign w_ctl.shift = w_out_acc;

    always_comb begin
        n_count    = r_count;
        n_drain    = r_drain;
        n_overflow = r_overflow;
        if (w_in_acc) begin
            if (w_full) begin
                n_overflow = 1'b1;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
            if (i_last_record) begin
                n_drain = 1'b1;
            end
        end
        if (w_out_acc) begin
            n_count = r_count - CNT_W'(1);
            if (r_count == CNT_W'(1)) begin
                n_drain    = 1'b0;
                n_overflow = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_drain    <= 1'b0;
            r_overflow <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_drain    <= n_drain;
            r_overflow <= n_overflow;
        end
    end

    for (genvar g = 0; g < MAX_RECORDS; g++) begin : g_cell
        logic           w_prev_gt;
        flrs_pkg::t_key w_prev_key;
        flrs_pkg::t_tag w_prev_tag;
        flrs_pkg::t_key w_next_key;
        flrs_pkg::t_tag w_next_tag;

        assign w_occ[g] = (r_count > CNT_W'(g));

        if (g == 0) begin : g_head
            assign w_prev_gt  = 1'b0;
            assign w_prev_key = '0;
            assign w_prev_tag = '0;
        end else begin : g_body
            assign w_prev_gt  = w_gt[g-1];
            assign w_prev_key = w_key[g-1];
            assign w_prev_tag = w_tag[g-1];
        end

        if (g == MAX_RECORDS - 1) begin : g_tail
            assign w_next_key = '0;
            assign w_next_tag = '0;
        end else begin : g_mid
            assign w_next_key = w_key[g+1];
            assign w_next_tag = w_tag[g+1];
        end

        flrs_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_occupied (w_occ[g]),
            .i_new_key  (i_first_char),
            .i_new_tag  (i_record_tag),
            .i_prev_gt  (w_prev_gt),
            .i_prev_key (w_prev_key),
            .i_prev_tag (w_prev_tag),
            .i_next_key (w_next_key),
            .i_next_tag (w_next_tag),
            .o_gt       (w_gt[g]),
            .o_key      (w_key[g]),
            .o_tag      (w_tag[g])
        );
    end

    assign o_sorted_char = w_key[0];
    assign o_sorted_tag  = w_tag[0];
    assign o_overflow    = r_overflow;
    assign o_last_out    = (r_count == CNT_W'(1));

endmodule

/* rtl/flrs_checker.sv */
// port-level checks on the record sorter, bound to the top level
// uses assert_macros.svh
`include "assert_macros.svh"

module flrs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       i_last_record,
    input logic       o_valid,
    input logic       i_stall,
    input logic [5:0] o_sorted_tag,
    input logic [7:0] o_sorted_char,
    input logic       o_overflow,
    input logic       o_last_out
);

    // a stalled result item holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_sorted_tag) && $stable(o_sorted_char))

    // no item is taken in while a run is being emitted
    `ASSERT_IMPL(a_in_blocked, i_clk, i_rst_n, o_valid, o_stall)

    // the last record of a set starts the run in the next cycle
    `ASSERT_NEXT(a_run_start, i_clk, i_rst_n, i_valid && !o_stall && i_last_record, o_valid)

    // the run ends after the item marked last
    `ASSERT_NEXT(a_run_end, i_clk, i_rst_n, o_valid && !i_stall && o_last_out, !o_valid)

    // overflow flag is the same on every item of a run
    `ASSERT_NEXT(a_ovf_steady, i_clk, i_rst_n, o_valid && !i_stall && !o_last_out, o_valid && $stable(o_overflow))

endmodule

bind first_letter_record_sorter flrs_checker u_flrs_checker (.*);

/* tb/sv/first_letter_record_sorter_test.sv */
// self-checking test of first_letter_record_sorter: directed and random sets sorted by folded key
// depends on flrs_pkg and the first_letter_record_sorter rtl
module first_letter_record_sorter_test;

    localparam int MAX_RECORDS  = 64;
    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_ITEMS = 360;

    typedef struct packed {
        flrs_pkg::t_tag tag;
        flrs_pkg::t_key ch;
        logic           ovf;
        logic           last;
    } t_sorted_entry;

    // models the record store and emits the sorted run when a set closes
    class sort_scoreboard;
        flrs_pkg::t_key held_key [MAX_RECORDS];
        flrs_pkg::t_tag held_tag [MAX_RECORDS];
        int unsigned    held_count;
        bit             dropped;
        t_sorted_entry  sorted_q [$];
        int unsigned    fail_count;

        function new();
            held_count = 0;
            dropped    = 1'b0;
            fail_count = 0;
        endfunction

        function flrs_pkg::t_key lower_case_key(input flrs_pkg::t_key c);
            if (c >= 8'h41 && c <= 8'h5A) begin
                return c | 8'h20;
            end
            return c;
        endfunction

        function void note_record(input flrs_pkg::t_key ch, input flrs_pkg::t_tag tag,
                                  input logic last);
            flrs_pkg::t_key k;
            flrs_pkg::t_tag t;
            int unsigned    j;
            t_sorted_entry  e;
            if (held_count < MAX_RECORDS) begin
                held_key[held_count] = ch;
                held_tag[held_count] = tag;
                held_count++;
            end else begin
                dropped = 1'b1;
            end
            if (!last) begin
                return;
            end
            // insertion sort, strict compare keeps equal keys in arrival order
            for (int unsigned i = 1; i < held_count; i++) begin
                k = held_key[i];
                t = held_tag[i];
                j = i;
                while (j > 0 && lower_case_key(held_key[j-1]) > lower_case_key(k)) begin
                    held_key[j] = held_key[j-1];
                    held_tag[j] = held_tag[j-1];
                    j--;
                end
                held_key[j] = k;
                held_tag[j] = t;
            end
            for (int unsigned i = 0; i < held_count; i++) begin
                e.tag  = held_tag[i];
                e.ch   = held_key[i];
                e.ovf  = dropped;
                e.last = (i + 1 == held_count);
                sorted_q.push_back(e);
            end
            held_count = 0;
            dropped    = 1'b0;
        endfunction

        function void check_result(input flrs_pkg::t_tag tag, input flrs_pkg::t_key ch,
                                   input logic ovf, input logic last);
            t_sorted_entry e;
            if (sorted_q.size() == 0) begin
                $error("result with no record pending: tag %0d char %0h", tag, ch);
                fail_count++;
                return;
            end
            e = sorted_q.pop_front();
            if (tag !== e.tag) begin
                $error("sorted_tag mismatch: expected %0d, actual %0d", e.tag, tag);
                fail_count++;
            end
            if (ch !== e.ch) begin
                $error("sorted_char mismatch: expected %0h, actual %0h", e.ch, ch);
                fail_count++;
            end
            if (ovf !== e.ovf) begin
                $error("overflow mismatch: expected %0d, actual %0d", e.ovf, ovf);
                fail_count++;
            end
            if (last !== e.last) begin
                $error("last_out mismatch: expected %0d, actual %0d", e.last, last);
                fail_count++;
            end
        endfunction

        function int pending();
            return sorted_q.size();
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic [7:0]  i_first_char  = 8'h00;
    logic [5:0]  i_record_tag  = 6'h00;
    logic        i_last_record = 1'b0;
    logic        i_stall       = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [5:0]  o_sorted_tag;
    logic [7:0]  o_sorted_char;
    logic        o_overflow;
    logic        o_last_out;

    bit             calm = 1'b0;
    int unsigned    cycle_count = 0;
    sort_scoreboard record_book;

    first_letter_record_sorter #(
        .MAX_RECORDS(MAX_RECORDS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_first_char  (i_first_char),
        .i_record_tag  (i_record_tag),
        .i_last_record (i_last_record),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_sorted_tag  (o_sorted_tag),
        .o_sorted_char (o_sorted_char),
        .o_overflow    (o_overflow),
        .o_last_out    (o_last_out)
    );

    initial begin
        forever begin
            #10 i_clk = ~i_clk;
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("first_letter_record_sorter_test: FAIL");
        $finish;
    end

    // letters and case boundaries are weighted up so that ties and folding get hit
    function automatic flrs_pkg::t_key pick_key();
        logic [7:0] edges [8] = '{8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B};
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel <= 2) begin
            return 8'h41 + 8'($urandom_range(25));
        end else if (sel <= 5) begin
            return 8'h61 + 8'($urandom_range(25));
        end else if (sel == 6) begin
            return edges[$urandom_range(7)];
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic int unsigned pick_set_size(input int unsigned set_index);
        int unsigned sel;
        if (set_index == 0) begin
            return MAX_RECORDS;
        end else if (set_index == 1) begin
            return MAX_RECORDS + 2;
        end
        sel = $urandom_range(99);
        if (sel < 80) begin
            return $urandom_range(8, 1);
        end else if (sel < 90) begin
            return $urandom_range(MAX_RECORDS - 1, 9);
        end else if (sel < 95) begin
            return MAX_RECORDS;
        end
        return $urandom_range(MAX_RECORDS + 4, MAX_RECORDS + 1);
    endfunction

    task automatic send_record(input flrs_pkg::t_key ch, input flrs_pkg::t_tag tag,
                               input logic last);
        while (!calm && $urandom_range(99) < 25) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_first_char  <= ch;
        i_record_tag  <= tag;
        i_last_record <= last;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        record_book.note_record(ch, tag, last);
    endtask

    // result side: check at the edge, then pick the stall for the next cycle
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                record_book.check_result(o_sorted_tag, o_sorted_char, o_overflow, o_last_out);
            end
            i_stall <= !calm && ($urandom_range(99) < 25);
        end
    end

    initial begin
        int unsigned random_items;
        int unsigned set_index;
        int unsigned set_size;
        record_book  = new();
        random_items = 0;
        set_index    = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // single record set
        send_record(8'h4D, 6'd0, 1'b1);
        // byte extremes, case boundaries and an 'a' before 'A' tie
        send_record(8'hFF, 6'd63, 1'b0);
        send_record(8'h00, 6'd1, 1'b0);
        send_record(8'h80, 6'd2, 1'b0);
        send_record(8'h5A, 6'd3, 1'b0);
        send_record(8'h61, 6'd4, 1'b0);
        send_record(8'h41, 6'd5, 1'b0);
        send_record(8'h40, 6'd6, 1'b0);
        send_record(8'h5B, 6'd7, 1'b0);
        send_record(8'h60, 6'd8, 1'b0);
        send_record(8'h7B, 6'd9, 1'b0);
        send_record(8'h7A, 6'd42, 1'b1);
        // equal folded keys must keep arrival order
        send_record(8'h62, 6'd10, 1'b0);
        send_record(8'h42, 6'd11, 1'b0);
        send_record(8'h62, 6'd12, 1'b0);
        send_record(8'h42, 6'd13, 1'b0);
        send_record(8'h61, 6'd14, 1'b1);
        // already in order, then reversed
        send_record(8'h61, 6'd20, 1'b0);
        send_record(8'h62, 6'd21, 1'b1);
        send_record(8'h7A, 6'd30, 1'b0);
        send_record(8'h79, 6'd31, 1'b0);
        send_record(8'h78, 6'd32, 1'b1);

        // the first two sets fill the store exactly and then overrun it
        while (random_items < RANDOM_ITEMS) begin
            set_size = pick_set_size(set_index);
            calm = (random_items >= 120 && random_items < 220);
            for (int unsigned k = 0; k < set_size; k++) begin
                send_record(pick_key(), flrs_pkg::t_tag'($urandom_range(63)),
                            k + 1 == set_size);
            end
            random_items += set_size;
            set_index++;
        end
        calm    = 1'b0;
        i_valid <= 1'b0;

        while (record_book.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);

        if (record_book.fail_count == 0 && record_book.pending() == 0) begin
            $display("first_letter_record_sorter_test: PASS");
        end else begin
            $display("first_letter_record_sorter_test: FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/flrs_pkg.sv
rtl/flrs_cell.sv
rtl/first_letter_record_sorter.sv
rtl/flrs_checker.sv
tb/sv/first_letter_record_sorter_test.sv
